### rtl/core/lrupr_pkg.sv
// Shared constants and types for the LRU page replacement block.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_W      = 20;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 4;
  localparam int RANK_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int OCC_W       = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W       = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam int IN_TDATA_W  = ((PAGE_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + PAGE_W + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(3);

  typedef struct packed {
    logic              hit;
    logic              victim_valid;
    logic [PAGE_W-1:0] victim_page;
  } lrupr_lookup_t;

endpackage

### rtl/core/lrupr_frame_store.sv
// Frame tags, valid bits and recency ranks with parallel lookup and LRU update.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_frame_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lrupr_pkg::PAGE_W-1:0]  page_i,
  input  logic [lrupr_pkg::CFG_W-1:0]   frame_count_i,
  input  logic                          update_i,
  output lrupr_pkg::lrupr_lookup_t      lookup_o
);
  import lrupr_pkg::*;

  logic [PAGE_W-1:0]     page_q  [MAX_FRAMES];
  logic [RANK_W-1:0]     rank_q  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;

  logic [MAX_FRAMES-1:0] hit_oh, empty_oh, lru_oh, load_oh;
  logic [OCC_W-1:0]      occ, occ_m1;
  logic [RANK_W-1:0]     hit_rank, last_rank;
  logic [LIM_W-1:0]      lim;
  logic [PAGE_W-1:0]     lru_page;
  logic                  hit, evict, empty_found;

  always_comb begin
    occ         = '0;
    hit_oh      = '0;
    empty_oh    = '0;
    hit_rank    = '0;
    empty_found = 1'b0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      occ = occ + OCC_W'(valid_q[i]);
      if (valid_q[i] && page_q[i] == page_i) begin
        hit_oh[i] = 1'b1;
      end
      if (!valid_q[i] && !empty_found) begin
        empty_oh[i] = 1'b1;
        empty_found = 1'b1;
      end
    end
    hit = |hit_oh;

    // valid frames hold ranks 0..occ-1, so the LRU frame has rank occ-1
    occ_m1    = occ - OCC_W'(1);
    last_rank = occ_m1[RANK_W-1:0];
    lru_oh    = '0;
    lru_page  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (valid_q[i] && rank_q[i] == last_rank) begin
        lru_oh[i] = 1'b1;
        lru_page  = lru_page | page_q[i];
      end
      if (hit_oh[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
    end

    lim = LIM_W'(frame_count_i);
    if (lim == '0) begin
      lim = LIM_W'(1);
    end else if (lim > LIM_W'(MAX_FRAMES)) begin
      lim = LIM_W'(MAX_FRAMES);
    end

    evict   = !hit && (|valid_q) && ((LIM_W'(occ) >= lim) || (&valid_q));
    load_oh = evict ? lru_oh : empty_oh;

    lookup_o.hit          = hit;
    lookup_o.victim_valid = evict;
    lookup_o.victim_page  = evict ? lru_page : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (update_i) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (hit) begin
          if (hit_oh[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && rank_q[i] < hit_rank) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end else if (load_oh[i]) begin
          valid_q[i] <= 1'b1;
          rank_q[i]  <= '0;
        end else if (valid_q[i]) begin
          rank_q[i] <= rank_q[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (update_i && !hit && load_oh[i]) begin
        page_q[i] <= page_i;
      end
    end
  end

  // resident pages are distinct
  a_hit_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_oh))
    else $error("more than one frame matched the page");

  a_lru_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|valid_q) |-> $onehot(lru_oh))
    else $error("LRU frame not unique among valid frames");

  a_miss_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && !hit) |=> (|valid_q))
    else $error("miss left the store empty");

endmodule

### rtl/core/lrupr_stats.sv
// Saturating hit and fault counters.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_stats (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        update_i,
  input  logic                        hit_i,
  output logic [lrupr_pkg::CNT_W-1:0] hit_total_o,
  output logic [lrupr_pkg::CNT_W-1:0] fault_total_o
);
  import lrupr_pkg::*;

  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] fault_cnt_q, fault_cnt_d;

  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    fault_cnt_d = fault_cnt_q;
    if (update_i && hit_i && hit_cnt_q != '1) begin
      hit_cnt_d = hit_cnt_q + CNT_W'(1);
    end
    if (update_i && !hit_i && fault_cnt_q != '1) begin
      fault_cnt_d = fault_cnt_q + CNT_W'(1);
    end
  end

  // totals after the current word
  assign hit_total_o   = hit_cnt_d;
  assign fault_total_o = fault_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
    end else begin
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
    end
  end

  a_hit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && hit_i) |=> (hit_cnt_q != '0))
    else $error("hit counter zero after a hit");

  a_idle_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !update_i |=> ($stable(hit_cnt_q) && $stable(fault_cnt_q)))
    else $error("counters moved without a lookup");

endmodule

### rtl/core/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: stream ports, input and
// result registers, frame_count register.
// Depends on lrupr_pkg, lrupr_frame_store and lrupr_stats.
//
// Usage:
//   Slave stream carries one page reference per word (page number in the low
//   bits of s_axis_tdata_i). Master stream returns one result word per
//   reference: hit flag, victim flag and page, and running hit and fault
//   totals. cfg_we_i/cfg_wdata_i write frame_count (frames in use, 1..8;
//   0 acts as 1). Write it only while no reference is in flight.
//   Path: input register, then result register, which drives the master side.
//   Throughput: one reference per cycle while the master side does not stall;
//   the lookup and LRU pick are combinational across all frames in parallel
//   and the rank update is registered; the next word sees the updated store.
//   Reset: all frames empty, counters zero, frame_count 3.
//   Stall: the result register holds while m_axis_tready_i is low; one more
//   reference is taken into the input register, then s_axis_tready_o drops.
`timescale 1ns / 1ps

module lru_page_replacement_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cfg: frame_count
  input  logic                              cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]       cfg_wdata_i,
  // tdata: page_number
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tdata: hit, victim_valid, victim_page, hit_total, fault_total
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0]  frame_count_q;
  logic              in_valid_q, in_valid_d;
  logic [PAGE_W-1:0] in_page_q;
  logic              out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0] out_data_q;

  lrupr_lookup_t     lookup;
  logic [CNT_W-1:0]  hit_total, fault_total;
  logic              s_acc, advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  lrupr_frame_store u_frame_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .page_i        (in_page_q),
    .frame_count_i (frame_count_q),
    .update_i      (advance),
    .lookup_o      (lookup)
  );

  lrupr_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (advance),
    .hit_i         (lookup.hit),
    .hit_total_o   (hit_total),
    .fault_total_o (fault_total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_page_q <= s_axis_tdata_i[PAGE_W-1:0];
    end
    if (advance) begin
      out_data_q <= {fault_total, hit_total, lookup.victim_page,
                     lookup.victim_valid, lookup.hit};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_data_q);

  a_advance_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word did not reach the result register");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while both stages full and stalled");

endmodule

### sim/lru_page_replacement_top_tb.sv
// Self-checking testbench for lru_page_replacement_top: drives page references
// on the slave stream and checks each result word against a predictor.
// Depends on lrupr_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;
  import lrupr_pkg::*;

  // Mirrors the frame store: pages, occupancy, recency ranks and counters.
  class lru_frame_tracker;
    logic [PAGE_W-1:0] page_at[MAX_FRAMES];
    bit                occupied_at[MAX_FRAMES];
    int unsigned       rank_at[MAX_FRAMES];
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  faults;
    logic [CFG_W-1:0]  frame_count;
    // expected words, oldest first: {fault_total, hit_total, victim_page, victim_valid, hit}
    logic [OUT_BITS-1:0] pending_results[$];
    int                  errors;
    int                  refs_seen;
    int                  victims_seen;

    function new();
      for (int i = 0; i < MAX_FRAMES; i++) begin
        page_at[i]     = '0;
        occupied_at[i] = 1'b0;
        rank_at[i]     = 0;
      end
      hits         = '0;
      faults       = '0;
      frame_count  = FRAME_COUNT_RST;
      errors       = 0;
      refs_seen    = 0;
      victims_seen = 0;
    endfunction

    function void set_frame_count(logic [CFG_W-1:0] v);
      frame_count = v;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_reference(logic [PAGE_W-1:0] page);
      int unsigned       occ;
      int                hit_slot;
      int                empty_slot;
      int                lru_slot;
      int                slot;
      int unsigned       lim;
      logic              hit;
      logic              vvalid;
      logic [PAGE_W-1:0] vpage;
      int unsigned       hit_rank;
      occ        = 0;
      hit_slot   = -1;
      empty_slot = -1;
      lru_slot   = -1;
      hit        = 1'b0;
      vvalid     = 1'b0;
      vpage      = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (occupied_at[i]) begin
          occ++;
          if (hit_slot < 0 && page_at[i] == page) hit_slot = i;
          if (lru_slot < 0 || rank_at[i] > rank_at[lru_slot]) lru_slot = i;
        end else if (empty_slot < 0) begin
          empty_slot = i;
        end
      end
      if (hit_slot >= 0) begin
        hit = 1'b1;
        if (hits != '1) hits = hits + 1'b1;
        hit_rank = rank_at[hit_slot];
        for (int i = 0; i < MAX_FRAMES; i++)
          if (occupied_at[i] && rank_at[i] < hit_rank) rank_at[i]++;
        rank_at[hit_slot] = 0;
      end else begin
        if (faults != '1) faults = faults + 1'b1;
        // zero acts as one, anything past capacity as full capacity
        lim = (frame_count == 0) ? 1 : int'(frame_count);
        if (lim > MAX_FRAMES) lim = MAX_FRAMES;
        if ((occ >= lim || empty_slot < 0) && lru_slot >= 0) begin
          vvalid = 1'b1;
          vpage  = page_at[lru_slot];
          slot   = lru_slot;
          occupied_at[slot] = 1'b0;
          victims_seen++;
        end else begin
          slot = (empty_slot >= 0) ? empty_slot : 0;
        end
        for (int i = 0; i < MAX_FRAMES; i++)
          if (occupied_at[i]) rank_at[i]++;
        page_at[slot]     = page;
        occupied_at[slot] = 1'b1;
        rank_at[slot]     = 0;
      end
      refs_seen++;
      pending_results.push_back({faults, hits, vpage, vvalid, hit});
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      logic [OUT_BITS-1:0] exp_w;
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding: %0h", word);
        errors++;
        return;
      end
      exp_w = pending_results.pop_front();
      compare_field("hit", CNT_W'(exp_w[0]), CNT_W'(word[0]));
      compare_field("victim_valid", CNT_W'(exp_w[1]), CNT_W'(word[1]));
      compare_field("victim_page", CNT_W'(exp_w[2 +: PAGE_W]), CNT_W'(word[2 +: PAGE_W]));
      compare_field("hit_total", exp_w[2 + PAGE_W +: CNT_W], word[2 + PAGE_W +: CNT_W]);
      compare_field("fault_total", exp_w[2 + PAGE_W + CNT_W +: CNT_W],
                    word[2 + PAGE_W + CNT_W +: CNT_W]);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  lru_frame_tracker tracker;
  int               idle_pct;
  bit               long_hold_req;
  int               settings_used;

  lru_page_replacement_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) tracker.check_result(m_axis_tdata_o);
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (40) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic send_reference(input logic [PAGE_W-1:0] page);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'(page);
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_reference(page);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] v);
    stop_sending();
    wait_drained();
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_frame_count(v);
    settings_used++;
  endtask

  // Mostly references from a small working set so hits and evictions both
  // happen often; the rest is fully random noise.
  task automatic run_phase(input logic [CFG_W-1:0] fc, input int n_refs, input int pause_at);
    logic [PAGE_W-1:0] pool[12];
    int                pool_n;
    logic [PAGE_W-1:0] page;
    write_frame_count(fc);
    pool_n = ((fc == 0) ? 1 : (fc > MAX_FRAMES ? MAX_FRAMES : int'(fc))) + $urandom_range(0, 3);
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 9))
        0:       pool[i] = '0;
        1:       pool[i] = '1;
        default: pool[i] = PAGE_W'($urandom);
      endcase
    end
    for (int k = 0; k < n_refs; k++) begin
      if (k == pause_at) begin
        stop_sending();
        wait_drained();
      end
      if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool_n - 1)];
      else page = PAGE_W'($urandom);
      send_reference(page);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_fc[12];
    tracker         = new();
    idle_pct        = 0;
    long_hold_req   = 1'b0;
    settings_used   = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default of three frames, edge page values, hit and eviction
    send_reference(20'h00000);
    send_reference(20'hFFFFF);
    send_reference(20'h00000);
    send_reference(20'h55555);
    send_reference(20'hAAAAA);
    send_reference(20'h55555);
    send_reference(20'h12345);
    // shrink below occupancy: store keeps its pages, each miss swaps one
    write_frame_count(4'd1);
    send_reference(20'h00001);
    send_reference(20'h00002);
    send_reference(20'h00001);
    // zero behaves as one
    write_frame_count(4'd0);
    send_reference(20'h00002);
    send_reference(20'h80000);
    // above capacity clamps to full size: fill every frame, then evict
    write_frame_count(4'd15);
    for (int i = 0; i < MAX_FRAMES; i++) send_reference(PAGE_W'(20'h10000 + i * 20'h01111));
    send_reference(20'hFFFFF);

    phase_fc = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd2, 4'd9, 4'd4, 4'd7, 4'd3, 4'd6, 4'd8};
    for (int p = 0; p < 12; p++) begin
      idle_pct = (p == 11) ? 0 : ((p % 3 == 2) ? 0 : 25);
      if (p == 2) long_hold_req = 1'b1;
      run_phase(phase_fc[p], 115, (p == 4) ? 60 : -1);
    end
    stop_sending();
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d page references, %0d evictions, %0d frame_count settings.",
             tracker.refs_seen, tracker.victims_seen, settings_used);
    $display("Final totals: %0d hits, %0d faults.", tracker.hits, tracker.faults);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_frame_store.sv
rtl/core/lrupr_stats.sv
rtl/core/lru_page_replacement_top.sv
sim/lru_page_replacement_top_tb.sv
